### hw/rtl/tpaf_pkg.sv
package tpaf_pkg;

  localparam int PERIOD_W   = 16;
  localparam int LEVEL_W    = 12;
  localparam int BLINK_W    = 10;
  localparam int OPCODE_W   = 2;
  localparam int CHAN_W     = 3;
  localparam int GATE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0]  LEVEL_LOW_CUT  = 12'd128;
  localparam logic [LEVEL_W-1:0]  LEVEL_HIGH_CUT = 12'd3967;
  localparam logic [LEVEL_W-1:0]  LEVEL_FULL     = 12'd4095;
  localparam int                  DELAY_SHIFT    = 12;
  localparam logic [PERIOD_W-1:0] TICK_MAX       = 16'hFFFF;

  localparam logic [PERIOD_W-1:0] NOMINAL_RST = 16'd100;
  localparam logic [PERIOD_W-1:0] PULSE_RST   = 16'd5;
  localparam logic [BLINK_W-1:0]  BLINK_RST   = 10'd100;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK      = 2'd0,
    OP_CROSS     = 2'd1,
    OP_SET_LEVEL = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NOMINAL    = 2'd0,
    CFG_GATE_PULSE = 2'd1,
    CFG_SIMULATE   = 2'd2,
    CFG_BLINK      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] tick;
    logic [PERIOD_W-1:0] pulse;
    logic                simulate;
  } gate_ctl_t;

endpackage

### hw/rtl/tpaf_ifs.sv
interface tpaf_cmd_if import tpaf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [CHAN_W-1:0]   channel;
  logic [LEVEL_W-1:0]  level;

  modport source(output valid, output opcode, output channel, output level, input ready);
  modport sink(input valid, input opcode, input channel, input level, output ready);
endinterface

interface tpaf_rsp_if import tpaf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [GATE_W-1:0]   gate_drive;
  logic                heartbeat_led;
  logic [PERIOD_W-1:0] last_period;

  modport source(output valid, output gate_drive, output heartbeat_led, output last_period,
                 input ready);
  modport sink(input valid, input gate_drive, input heartbeat_led, input last_period,
               output ready);
endinterface

### hw/rtl/tpaf_delay_calc.sv
module tpaf_delay_calc import tpaf_pkg::*; (
  input  logic [PERIOD_W-1:0] nominal,
  input  logic [LEVEL_W-1:0]  level,
  output logic [PERIOD_W-1:0] delay
);

  localparam int PROD_W = PERIOD_W + LEVEL_W;

  logic [LEVEL_W-1:0] headroom;
  logic [PROD_W-1:0]  product;

  assign headroom = LEVEL_FULL - level;
  assign product  = PROD_W'(nominal) * PROD_W'(headroom);
  assign delay    = product[DELAY_SHIFT +: PERIOD_W];

endmodule

### hw/rtl/tpaf_gate_eval.sv
module tpaf_gate_eval import tpaf_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  gate_ctl_t           ctl,
  input  logic [PERIOD_W-1:0] delay [CHANNELS],
  output logic [CHANNELS-1:0] lane_on
);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      logic [PERIOD_W:0] window_end;
      window_end = {1'b0, delay[c]} + {1'b0, ctl.pulse};
      if (ctl.simulate) begin
        lane_on[c] = (ctl.tick > delay[c]);
      end else begin
        lane_on[c] = (ctl.tick < delay[c]) || ({1'b0, ctl.tick} > window_end);
      end
    end
  end

endmodule

### hw/rtl/triac_phase_angle_firing.sv
// a request waits in the input register and moves into the result register when it is processed
// throughput: one request per cycle while no delay pass runs and results are taken, one result per request
// reset: synchronous, clears counters, levels, led and gate bits; config to defaults
// after reset and after every nominal period write a pass over all CHANNELS channels (8 by default)
// recomputes the channel delays through the shared multiplier, requests wait meanwhile
module triac_phase_angle_firing import tpaf_pkg::*; #(
  parameter int CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  tpaf_cmd_if.sink              cmd,
  tpaf_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration
  logic [PERIOD_W-1:0] nominal;
  logic [PERIOD_W-1:0] pulse;
  logic                simulate;
  logic [BLINK_W-1:0]  blink;

  // input register
  logic                in_full;
  logic [OPCODE_W-1:0] op_q;
  logic [CHAN_W-1:0]   ch_q;
  logic [LEVEL_W-1:0]  lvl_q;

  // state
  logic [PERIOD_W-1:0] tick_count, tick_count_next;
  logic [PERIOD_W-1:0] period_seen, period_seen_next;
  logic [BLINK_W-1:0]  crossing_count, crossing_count_next;
  logic                led_state, led_state_next;
  logic [GATE_W-1:0]   gate_bits, gate_bits_next;
  logic [LEVEL_W-1:0]  levels [CHANNELS];
  logic [PERIOD_W-1:0] delays [CHANNELS];

  // delay recompute pass
  logic             sweep_active;
  logic [IDX_W-1:0] sweep_idx;
  logic             sweep_last;

  // output register
  logic                out_full;
  logic [GATE_W-1:0]   rsp_gate;
  logic                rsp_led;
  logic [PERIOD_W-1:0] rsp_period;

  logic                process;
  logic                do_cross;
  logic                gate_update;
  logic                level_write;
  logic                ch_ok;
  logic [PERIOD_W-1:0] tick_inc;
  logic [BLINK_W-1:0]  cross_inc;
  logic [LEVEL_W-1:0]  lvl_clamped;
  logic [LEVEL_W-1:0]  mult_level;
  logic [PERIOD_W-1:0] mult_delay;
  logic [CHANNELS-1:0] lane_on;
  logic [GATE_W-1:0]   gate_eval_bits;
  gate_ctl_t           gate_ctl;

  assign process   = in_full && !sweep_active && (!out_full || rsp.ready);
  assign cmd.ready = !in_full || process;

  assign rsp.valid         = out_full;
  assign rsp.gate_drive    = rsp_gate;
  assign rsp.heartbeat_led = rsp_led;
  assign rsp.last_period   = rsp_period;

  assign ch_ok      = ({29'd0, ch_q} < 32'(CHANNELS));
  assign sweep_last = (sweep_idx == IDX_W'(CHANNELS - 1));

  always_comb begin
    if (lvl_q < LEVEL_LOW_CUT) begin
      lvl_clamped = '0;
    end else if (lvl_q > LEVEL_HIGH_CUT) begin
      lvl_clamped = LEVEL_FULL;
    end else begin
      lvl_clamped = lvl_q;
    end
  end

  assign mult_level = sweep_active ? levels[sweep_idx] : lvl_clamped;

  tpaf_delay_calc u_delay_calc (
    .nominal (nominal),
    .level   (mult_level),
    .delay   (mult_delay)
  );

  // event decode and counter update
  always_comb begin
    tick_count_next     = tick_count;
    period_seen_next    = period_seen;
    crossing_count_next = crossing_count;
    led_state_next      = led_state;
    do_cross            = 1'b0;
    gate_update         = 1'b0;
    level_write         = 1'b0;
    tick_inc            = (tick_count != TICK_MAX) ? tick_count + 1'b1 : tick_count;
    cross_inc           = crossing_count + 1'b1;
    case (op_q)
      OP_TICK: begin
        tick_count_next = tick_inc;
        gate_update     = 1'b1;
        do_cross        = simulate && (tick_inc == nominal);
      end
      OP_CROSS: begin
        do_cross = !simulate;
      end
      OP_SET_LEVEL: begin
        level_write = ch_ok;
      end
      default: begin
      end
    endcase
    if (do_cross) begin
      period_seen_next = tick_count_next;
      tick_count_next  = '0;
      if (cross_inc == blink) begin
        crossing_count_next = '0;
        led_state_next      = !led_state;
      end else begin
        crossing_count_next = cross_inc;
      end
    end
  end

  assign gate_ctl.tick     = tick_count_next;
  assign gate_ctl.pulse    = pulse;
  assign gate_ctl.simulate = simulate;

  tpaf_gate_eval #(
    .CHANNELS (CHANNELS)
  ) u_gate_eval (
    .ctl     (gate_ctl),
    .delay   (delays),
    .lane_on (lane_on)
  );

  for (genvar g = 0; g < GATE_W; g++) begin : g_gate_map
    if (g < CHANNELS) begin : g_lane
      assign gate_eval_bits[g] = lane_on[g];
    end else begin : g_none
      assign gate_eval_bits[g] = 1'b0;
    end
  end

  assign gate_bits_next = gate_update ? gate_eval_bits : gate_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      nominal  <= NOMINAL_RST;
      pulse    <= PULSE_RST;
      simulate <= 1'b0;
      blink    <= BLINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NOMINAL:    nominal  <= cfg_data[PERIOD_W-1:0];
        CFG_GATE_PULSE: pulse    <= cfg_data[PERIOD_W-1:0];
        CFG_SIMULATE:   simulate <= cfg_data[0];
        CFG_BLINK:      blink    <= cfg_data[BLINK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_active <= 1'b1;
      sweep_idx    <= '0;
    end else if (cfg_we && (cfg_index == CFG_NOMINAL)) begin
      sweep_active <= 1'b1;
      sweep_idx    <= '0;
    end else if (sweep_active) begin
      sweep_active <= !sweep_last;
      sweep_idx    <= sweep_last ? '0 : sweep_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q  <= cmd.opcode;
      ch_q  <= cmd.channel;
      lvl_q <= cmd.level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      period_seen    <= '0;
      crossing_count <= '0;
      led_state      <= 1'b0;
      gate_bits      <= '0;
    end else if (process) begin
      tick_count     <= tick_count_next;
      period_seen    <= period_seen_next;
      crossing_count <= crossing_count_next;
      led_state      <= led_state_next;
      gate_bits      <= gate_bits_next;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane_store
    logic set_hit;
    assign set_hit = process && level_write && ({29'd0, ch_q} == 32'(c));

    always_ff @(posedge clk) begin
      if (rst) begin
        levels[c] <= '0;
      end else if (set_hit) begin
        levels[c] <= lvl_clamped;
      end
    end

    always_ff @(posedge clk) begin
      if ((sweep_active && (sweep_idx == IDX_W'(c))) || set_hit) begin
        delays[c] <= mult_delay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (process) begin
      out_full <= 1'b1;
    end else if (rsp.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      rsp_gate   <= gate_bits_next;
      rsp_led    <= led_state_next;
      rsp_period <= period_seen_next;
    end
  end

  // a nominal period change always reruns the delay pass
  a_nominal_sweep: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index == CFG_NOMINAL)) |=> sweep_active)
    else $error("delay pass not started after nominal period write");

  // the led only changes as the crossing counter restarts
  a_led_toggle: assert property (@(posedge clk) disable iff (rst)
    !$stable(led_state) |-> (crossing_count == '0))
    else $error("led toggled without crossing counter restart");

  // every processed request lands in the result register
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    process |=> out_full)
    else $error("processed request produced no result");

  // no request is processed while channel delays are stale
  a_no_stale_delay: assert property (@(posedge clk) disable iff (rst)
    sweep_active |-> !process)
    else $error("request processed during delay pass");

endmodule
